FILE: hdl/gccd_pkg.sv
// Package: shared types and constants for the GLB container chunk deframer.
`default_nettype none
package gccd_pkg;

	localparam logic [31:0] CONTAINER_MAGIC  = 32'h4654_6C67;
	localparam logic [31:0] GLB_TYPE_JSON    = 32'h4E4F_534A;
	localparam logic [31:0] GLB_TYPE_BIN     = 32'h004E_4942;
	localparam logic [31:0] EXPECTED_VERSION = 32'd2;
	localparam logic [31:0] FILE_HDR_LEN     = 32'd12;
	localparam logic [31:0] CHUNK_HDR_LEN    = 32'd8;

	localparam logic [31:0] POS_MAGIC_END   = 32'd3;
	localparam logic [31:0] POS_VERSION_END = 32'd7;
	localparam logic [31:0] POS_FILE_LAST   = 32'd11;
	localparam logic [31:0] HDR_LEN_DONE    = 32'd5;

	typedef enum logic [1:0] {
		PH_FILE,
		PH_CHDR,
		PH_PAY,
		PH_IGN
	} phase_t;

	typedef logic [2:0] byte_class_t;
	localparam byte_class_t CLS_FILE  = 3'd0;
	localparam byte_class_t CLS_CHDR  = 3'd1;
	localparam byte_class_t CLS_JSON  = 3'd2;
	localparam byte_class_t CLS_BIN   = 3'd3;
	localparam byte_class_t CLS_OTHER = 3'd4;
	localparam byte_class_t CLS_IGN   = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_TOO_SHORT = 2'd1;
	localparam status_t ST_BAD_MAGIC = 2'd2;
	localparam status_t ST_NO_JSON   = 2'd3;

endpackage
`default_nettype wire

FILE: hdl/gccd_cfg_if.sv
// Interface: configuration write channel carrying the stream length.
`default_nettype none
interface gccd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/gccd_in_if.sv
// Interface: input byte channel.
`default_nettype none
interface gccd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/gccd_out_if.sv
// Interface: tagged output byte channel.
`default_nettype none
interface gccd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] byte_class;
	logic       chunk_start;
	logic       stream_done;
	logic [1:0] status;
	logic       version_warning;

	modport source (output valid, output out_byte, output byte_class, output chunk_start,
		output stream_done, output status, output version_warning, input ready);
	modport sink (input valid, input out_byte, input byte_class, input chunk_start,
		input stream_done, input status, input version_warning, output ready);
endinterface
`default_nettype wire

FILE: hdl/glb_container_chunk_deframer.sv
// Top level: GLB container deframer, tags each byte with its role in the container.
//
//  channel | dir | payload                                   | transfer when
//  cfg     | in  | data: stream_length (32)                  | valid && ready
//  din     | in  | data_byte (8)                             | valid && ready
//  dout    | out | out_byte, byte_class, chunk_start,        | valid && ready
//          |     | stream_done, status, version_warning      |
//
// One byte per cycle while dout takes results; a byte's result appears in the output register in the
// cycle after its transfer. Parse state updates in the transfer cycle.
// din.ready is low only while the output register holds a result dout does not take.
// cfg.ready is always high. Reset clears all parse state and stream_length.
`default_nettype none
module glb_container_chunk_deframer
	import gccd_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	gccd_cfg_if.sink    cfg,
	gccd_in_if.sink     din,
	gccd_out_if.source  dout
);

	logic [31:0] stream_length_q;
	logic [31:0] byte_position_q;
	phase_t      phase_q;
	logic [31:0] word_shift_q;
	logic [31:0] chunk_length_q;
	logic [31:0] chunk_type_q;
	logic [31:0] remaining_q;
	logic        json_seen_q;
	logic        bad_magic_q;
	logic        ver_warn_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	byte_class_t out_class_q;
	logic        out_start_q;
	logic        out_done_q;
	status_t     out_status_q;
	logic        out_warn_q;

	logic        in_xfer;
	logic        active;
	logic [31:0] left;
	logic [31:0] left_after;
	logic [31:0] ws_n;

	phase_t      phase_n;
	logic [31:0] chunk_length_n;
	logic [31:0] chunk_type_n;
	logic [31:0] remaining_n;
	logic        json_seen_n;
	logic        bad_magic_n;
	logic        ver_warn_n;
	byte_class_t cls;
	logic        start;
	logic        done;
	status_t     status;

	assign cfg.ready = 1'b1;
	assign din.ready = !out_valid_q || dout.ready;
	assign in_xfer   = din.valid && din.ready;

	assign active     = byte_position_q < stream_length_q;
	assign left       = stream_length_q - byte_position_q;
	assign left_after = left - 32'd1;
	assign ws_n       = {din.data_byte, word_shift_q[31:8]};

	always_comb begin
		phase_n        = phase_q;
		chunk_length_n = chunk_length_q;
		chunk_type_n   = chunk_type_q;
		remaining_n    = remaining_q;
		json_seen_n    = json_seen_q;
		bad_magic_n    = bad_magic_q;
		ver_warn_n     = ver_warn_q;
		cls            = CLS_IGN;
		start          = 1'b0;
		done           = 1'b0;
		status         = ST_OK;
		if (active) begin
			unique case (phase_q)
				PH_FILE: begin
					cls = CLS_FILE;
					if (byte_position_q == POS_MAGIC_END && ws_n != CONTAINER_MAGIC) begin
						bad_magic_n = 1'b1;
						phase_n     = PH_IGN;
					end else begin
						if (byte_position_q == POS_VERSION_END && ws_n != EXPECTED_VERSION)
							ver_warn_n = 1'b1;
						if (byte_position_q >= POS_FILE_LAST) begin
							phase_n     = PH_CHDR;
							remaining_n = CHUNK_HDR_LEN;
						end
					end
				end
				PH_CHDR: begin
					if (remaining_q == CHUNK_HDR_LEN && left < CHUNK_HDR_LEN) begin
						phase_n = PH_IGN;
					end else begin
						cls = CLS_CHDR;
						if (remaining_q == HDR_LEN_DONE)
							chunk_length_n = ws_n;
						if (remaining_q <= 32'd1) begin
							chunk_type_n = ws_n;
							if (chunk_length_q <= left_after) begin
								if (ws_n == GLB_TYPE_JSON)
									json_seen_n = chunk_length_q != 32'd0;
								if (chunk_length_q == 32'd0) begin
									remaining_n = CHUNK_HDR_LEN;
								end else begin
									phase_n     = PH_PAY;
									remaining_n = chunk_length_q;
								end
							end else begin
								phase_n = PH_IGN;
							end
						end else begin
							remaining_n = remaining_q - 32'd1;
						end
					end
				end
				PH_PAY: begin
					priority if (chunk_type_q == GLB_TYPE_JSON)
						cls = CLS_JSON;
					else if (chunk_type_q == GLB_TYPE_BIN)
						cls = CLS_BIN;
					else
						cls = CLS_OTHER;
					start = remaining_q == chunk_length_q;
					if (remaining_q <= 32'd1) begin
						phase_n     = PH_CHDR;
						remaining_n = CHUNK_HDR_LEN;
					end else begin
						remaining_n = remaining_q - 32'd1;
					end
				end
				PH_IGN: begin
					cls = CLS_IGN;
				end
				default: begin
					phase_n = PH_IGN;
				end
			endcase
			if (left == 32'd1) begin
				done = 1'b1;
				priority if (stream_length_q < FILE_HDR_LEN)
					status = ST_TOO_SHORT;
				else if (bad_magic_n)
					status = ST_BAD_MAGIC;
				else if (!json_seen_n)
					status = ST_NO_JSON;
				else
					status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			stream_length_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			phase_q         <= PH_FILE;
			word_shift_q    <= '0;
			chunk_length_q  <= '0;
			chunk_type_q    <= '0;
			remaining_q     <= '0;
			json_seen_q     <= 1'b0;
			bad_magic_q     <= 1'b0;
			ver_warn_q      <= 1'b0;
		end else if (in_xfer && active) begin
			byte_position_q <= byte_position_q + 32'd1;
			phase_q         <= phase_n;
			word_shift_q    <= ws_n;
			chunk_length_q  <= chunk_length_n;
			chunk_type_q    <= chunk_type_n;
			remaining_q     <= remaining_n;
			json_seen_q     <= json_seen_n;
			bad_magic_q     <= bad_magic_n;
			ver_warn_q      <= ver_warn_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (din.ready) begin
			out_valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_byte_q   <= din.data_byte;
			out_class_q  <= cls;
			out_start_q  <= start;
			out_done_q   <= done;
			out_status_q <= status;
			out_warn_q   <= ver_warn_n;
		end
	end

	assign dout.valid           = out_valid_q;
	assign dout.out_byte        = out_byte_q;
	assign dout.byte_class      = out_class_q;
	assign dout.chunk_start     = out_start_q;
	assign dout.stream_done     = out_done_q;
	assign dout.status          = out_status_q;
	assign dout.version_warning = out_warn_q;

	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> remaining_q != 32'd0)
		else $error("payload phase with zero bytes remaining");

	a_chdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHDR |-> (remaining_q >= 32'd1 && remaining_q <= CHUNK_HDR_LEN))
		else $error("chunk header counter out of range");

	a_start_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_start_q |->
			(out_class_q == CLS_JSON || out_class_q == CLS_BIN || out_class_q == CLS_OTHER))
		else $error("chunk start on a non-payload byte");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_done_q |-> out_status_q == ST_OK)
		else $error("status reported without done");

	a_magic_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		bad_magic_q |-> phase_q == PH_IGN)
		else $error("parsing continued after bad magic");

endmodule
`default_nettype wire

FILE: tb/tb_glb_container_chunk_deframer.sv
// Testbench: streams GLB containers through the deframer and checks every tagged byte.
`default_nettype none
module tb_glb_container_chunk_deframer;
	timeunit 1ns;
	timeprecision 1ps;
	import gccd_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned HOLD_AT      = 300;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned QUIET_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0]  out_byte;
		byte_class_t byte_class;
		logic        chunk_start;
		logic        stream_done;
		status_t     status;
		logic        version_warning;
	} tag_t;

	typedef enum logic [1:0] {
		ROW_LENGTH,
		ROW_BYTE,
		ROW_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;
		tag_t        tag;
	} row_t;

	localparam tag_t NO_TAG = '0;

	// magic, too-short end, bytes past the end, version warning, one JSON chunk
	row_t directed [24] = '{
		'{ROW_KNOWN, 32'hFF, '{8'hFF, CLS_IGN, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_LENGTH, 32'd5, NO_TAG},
		'{ROW_KNOWN, 32'h67, '{8'h67, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h6C, '{8'h6C, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h54, '{8'h54, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h46, '{8'h46, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h02, '{8'h02, CLS_FILE, 1'b0, 1'b1, ST_TOO_SHORT, 1'b0}},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_IGN, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_LENGTH, 32'd22, NO_TAG},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{ROW_KNOWN, 32'h80, '{8'h80, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'hFF, '{8'hFF, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'hFF, '{8'hFF, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'hFF, '{8'hFF, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'hFF, '{8'hFF, CLS_FILE, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h02, '{8'h02, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h00, '{8'h00, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h4A, '{8'h4A, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h53, '{8'h53, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h4F, '{8'h4F, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}},
		'{ROW_KNOWN, 32'h4E, '{8'h4E, CLS_CHDR, 1'b0, 1'b0, ST_OK, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	gccd_cfg_if cfg();
	gccd_in_if  din();
	gccd_out_if dout();

	glb_container_chunk_deframer i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.din   (din),
		.dout  (dout)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// parser image
	logic [31:0] stream_len_q   = '0;
	logic [31:0] pos_q          = '0;
	phase_t      phase_q        = PH_FILE;
	logic [31:0] shift_q        = '0;
	logic [31:0] chunk_len_q    = '0;
	logic [31:0] chunk_type_q   = '0;
	logic [31:0] remaining_q    = '0;
	logic        json_seen_q    = 1'b0;
	logic        bad_magic_q    = 1'b0;
	logic        version_warn_q = 1'b0;

	tag_t        expected_tags [$];
	logic [7:0]  burst [$];
	int unsigned mismatches    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned parsed_items  = 0;
	int unsigned send_idle_pct = 33;
	int unsigned recv_idle_pct = 69;
	logic        hold_req      = 1'b0;
	logic        hold_done     = 1'b0;
	int unsigned hold_left     = 0;

	function automatic tag_t tag_byte(input logic [7:0] b);
		tag_t        t;
		logic [31:0] left_after;
		t = '0;
		t.out_byte = b;
		t.byte_class = CLS_IGN;
		if (pos_q < stream_len_q) begin
			left_after = stream_len_q - pos_q - 32'd1;
			shift_q = {b, shift_q[31:8]};
			case (phase_q)
				PH_FILE: begin
					t.byte_class = CLS_FILE;
					if (pos_q == POS_MAGIC_END && shift_q != CONTAINER_MAGIC) begin
						bad_magic_q = 1'b1;
						phase_q = PH_IGN;
					end else if (pos_q == POS_VERSION_END && shift_q != EXPECTED_VERSION) begin
						version_warn_q = 1'b1;
					end
					if (phase_q == PH_FILE && pos_q >= POS_FILE_LAST) begin
						phase_q = PH_CHDR;
						remaining_q = CHUNK_HDR_LEN;
					end
				end
				PH_CHDR: begin
					if (remaining_q == CHUNK_HDR_LEN && stream_len_q - pos_q < CHUNK_HDR_LEN) begin
						phase_q = PH_IGN;
					end else begin
						t.byte_class = CLS_CHDR;
						if (remaining_q == HDR_LEN_DONE)
							chunk_len_q = shift_q;
						if (remaining_q <= 32'd1) begin
							chunk_type_q = shift_q;
							if (chunk_len_q <= left_after) begin
								if (chunk_type_q == GLB_TYPE_JSON)
									json_seen_q = (chunk_len_q != 32'd0);
								if (chunk_len_q == 32'd0) begin
									remaining_q = CHUNK_HDR_LEN;
								end else begin
									phase_q = PH_PAY;
									remaining_q = chunk_len_q;
								end
							end else begin
								phase_q = PH_IGN;
							end
						end else begin
							remaining_q--;
						end
					end
				end
				PH_PAY: begin
					if (chunk_type_q == GLB_TYPE_JSON)
						t.byte_class = CLS_JSON;
					else if (chunk_type_q == GLB_TYPE_BIN)
						t.byte_class = CLS_BIN;
					else
						t.byte_class = CLS_OTHER;
					t.chunk_start = (remaining_q == chunk_len_q);
					if (remaining_q <= 32'd1) begin
						phase_q = PH_CHDR;
						remaining_q = CHUNK_HDR_LEN;
					end else begin
						remaining_q--;
					end
				end
				default: ;
			endcase
			pos_q++;
			if (pos_q == stream_len_q) begin
				t.stream_done = 1'b1;
				if (stream_len_q < FILE_HDR_LEN)
					t.status = ST_TOO_SHORT;
				else if (bad_magic_q)
					t.status = ST_BAD_MAGIC;
				else if (!json_seen_q)
					t.status = ST_NO_JSON;
				else
					t.status = ST_OK;
			end
		end
		t.version_warning = version_warn_q;
		return t;
	endfunction

	function automatic void append_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			burst.push_back(w[8*k +: 8]);
	endfunction

	function automatic logic [31:0] pick_chunk_type();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			return GLB_TYPE_JSON;
		if (r < 70)
			return GLB_TYPE_BIN;
		if (r < 85)
			return GLB_TYPE_JSON ^ (32'd1 << $urandom_range(31));
		return $urandom;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at %0t ns: %s got 0x%0h, want 0x%0h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
		input tag_t known_tag = '0);
		tag_t t;
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.data_byte <= b;
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
		t = tag_byte(b);
		expected_tags.push_back(known ? known_tag : t);
	endtask

	task automatic drain_results();
		din.valid <= 1'b0;
		while (expected_tags.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_stream_length(input logic [31:0] value);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		stream_len_q = value;
	endtask

	task automatic send_burst(input logic counted);
		foreach (burst[k]) begin
			if (counted && parsed_items >= HOLD_AT && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			send_byte(burst[k]);
			if (counted)
				parsed_items++;
		end
	endtask

	// receiver
	initial begin
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		tag_t want;
		if ((din.valid && din.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end else if (arst_n && dout.valid && dout.ready) begin
			if (expected_tags.size() == 0) begin
				report_mismatch("unexpected result, out_byte", dout.out_byte, '0);
			end else begin
				want = expected_tags.pop_front();
				if (dout.out_byte !== want.out_byte)
					report_mismatch("out_byte", dout.out_byte, want.out_byte);
				if (dout.byte_class !== want.byte_class)
					report_mismatch("byte_class", dout.byte_class, want.byte_class);
				if (dout.chunk_start !== want.chunk_start)
					report_mismatch("chunk_start", dout.chunk_start, want.chunk_start);
				if (dout.stream_done !== want.stream_done)
					report_mismatch("stream_done", dout.stream_done, want.stream_done);
				if (dout.status !== want.status)
					report_mismatch("status", dout.status, want.status);
				if (dout.version_warning !== want.version_warning)
					report_mismatch("version_warning", dout.version_warning,
						want.version_warning);
			end
		end
	end

	initial begin
		int unsigned r;
		int unsigned n_chunks;
		int unsigned extra;
		int unsigned c;
		logic [31:0] len;
		arst_n <= 1'b0;
		din.valid <= 1'b0;
		din.data_byte <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_LENGTH)
				set_stream_length(directed[i].value);
			else
				send_byte(directed[i].value[7:0], directed[i].kind == ROW_KNOWN,
					directed[i].tag);
		end

		// chunk sequences; most are sized so the container ends on their last byte
		while (parsed_items < RANDOM_ITEMS) begin
			if (parsed_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 69;
			end else if (parsed_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 69;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			burst.delete();
			r = $urandom_range(99);
			if (r < 8) begin
				// length at or below the position: bytes past the end
				set_stream_length($urandom_range(1) ? 32'd0 : pos_q - $urandom_range(pos_q));
				repeat ($urandom_range(1, 4))
					burst.push_back(8'($urandom));
				send_burst(1'b0);
			end else begin
				n_chunks = $urandom_range(1, 4);
				for (c = 0; c < n_chunks; c++) begin
					if ($urandom_range(99) < 15)
						len = 32'd0;
					else if ($urandom_range(99) < 10)
						len = $urandom_range(20, 48);
					else
						len = $urandom_range(1, 10);
					append_word(len);
					append_word(pick_chunk_type());
					repeat (len)
						burst.push_back(8'($urandom));
				end
				set_stream_length(r < 18 ? 32'hFFFF_FFFF : pos_q + burst.size());
				send_burst(1'b1);
			end
		end

		// broken tail: oversized chunk or partial chunk header
		burst.delete();
		if ($urandom_range(1)) begin
			extra = $urandom_range(0, 12);
			append_word($urandom_range(1) ? extra + 1 + $urandom_range(500) : 32'hFFFF_FFFF);
			append_word(pick_chunk_type());
			repeat (extra)
				burst.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 7))
				burst.push_back(8'($urandom));
		end
		set_stream_length(pos_q + burst.size());
		send_burst(1'b0);

		burst.delete();
		repeat (6)
			burst.push_back(8'($urandom));
		set_stream_length(32'hFFFF_FFFF);
		send_burst(1'b0);

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_tags.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
